### hw/rtl/shs_pkg.sv
// Package for the SHA-256 stream hasher: round constants, initial hash values,
// the control and status structs between the sequencer and the compression core.
// No dependencies.
`default_nettype none
package shs_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned LenPos     = 56;
    localparam int unsigned Rounds     = 64;
    localparam int unsigned DigestWords = 8;

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenPosCnt = 6'(LenPos);
    localparam logic [2:0] LastIdx = 3'(DigestWords - 1);

    localparam logic [31:0] HashInit [DigestWords] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [31:0] RoundK [Rounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic       shift_en;  // push one byte into the block buffer
        logic [7:0] shift_byte;
        logic       start;     // compress the buffered block
        logic       restart;   // reload the initial hash values
        logic [2:0] rd_idx;
    } t_core_ctl;

    typedef struct packed {
        logic busy;
    } t_core_stat;

endpackage
`default_nettype wire

### hw/rtl/shs_if.sv
// Stream interfaces for the SHA-256 hasher: byte requests in, digest words out.
// No dependencies.
`default_nettype none
interface shs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
    modport source (output valid, data_byte, byte_present, end_of_message, input ready);
    modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface shs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

### hw/rtl/sha256_stream_hasher.sv
// SHA-256 stream hasher. Data byte requests are taken while idle; the 64th byte of a
// block starts a compression (64 rounds, then the chain fold) and the hasher waits.
// End of message shifts in the padding and length bytes (64 minus the fill, plus 64
// with an extra block), the length last, then sends 8 digest words.
// Synchronous active-low reset loads the initial hash values and clears the counts.
// Uses shs_pkg, shs_if and shs_compress.
`default_nettype none
module sha256_stream_hasher (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    shs_in_if.sink    i_in,
    shs_out_if.source o_out
);
    import shs_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WAIT  = 6'b000010,
        S_PAD80 = 6'b000100,
        S_PADZ  = 6'b001000,
        S_PADL  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state      r_st, n_st;
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_bits, n_bits;
    logic        r_end, n_end;   // finish pending after a full-block compress
    logic        r_pad, n_pad;   // padding in progress
    logic        r_fin, n_fin;   // length written, last compress running
    logic [2:0]  r_oidx, n_oidx;

    t_core_ctl   ctl;
    t_core_stat  stat;
    logic [31:0] word;
    logic        in_req, out_req;

    shs_compress u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (ctl),
        .o_stat (stat),
        .o_word (word)
    );

    assign in_req  = i_in.valid && i_in.ready;
    assign out_req = o_out.valid && o_out.ready;

    always_comb begin
        n_st   = r_st;
        n_fill = r_fill;
        n_bits = r_bits;
        n_end  = r_end;
        n_pad  = r_pad;
        n_fin  = r_fin;
        n_oidx = r_oidx;
        ctl    = '0;
        ctl.rd_idx = r_oidx;
        case (r_st)
            S_IDLE: begin
                if (in_req) begin
                    if (i_in.byte_present) begin
                        ctl.shift_en   = 1'b1;
                        ctl.shift_byte = i_in.data_byte;
                        n_fill = r_fill + 6'd1;
                        n_bits = r_bits + 64'd8;
                        if (r_fill == 6'(BlockBytes - 1)) begin
                            ctl.start = 1'b1;
                            n_end = i_in.end_of_message;
                            n_st  = S_WAIT;
                        end else if (i_in.end_of_message) begin
                            n_st = S_PAD80;
                        end
                    end else if (i_in.end_of_message) begin
                        n_st = S_PAD80;
                    end
                end
            end
            S_WAIT: begin
                if (!stat.busy) begin
                    if (r_fin) begin
                        n_st = S_OUT;
                    end else if (r_pad) begin
                        n_st = S_PADZ;
                    end else if (r_end) begin
                        n_st = S_PAD80;
                    end else begin
                        n_st = S_IDLE;
                    end
                end
            end
            S_PAD80: begin
                ctl.shift_en   = 1'b1;
                ctl.shift_byte = PadByte;
                n_fill = r_fill + 6'd1;
                n_end  = 1'b0;
                n_pad  = 1'b1;
                if (r_fill == 6'(BlockBytes - 1)) begin
                    ctl.start = 1'b1;
                    n_st = S_WAIT;
                end else begin
                    n_st = S_PADZ;
                end
            end
            S_PADZ: begin
                if (r_fill == LenPosCnt) begin
                    n_st = S_PADL;
                end else begin
                    ctl.shift_en = 1'b1;
                    n_fill = r_fill + 6'd1;
                    if (r_fill == 6'(BlockBytes - 1)) begin
                        ctl.start = 1'b1;
                        n_st = S_WAIT;
                    end
                end
            end
            S_PADL: begin
                // length goes out big-endian: top byte first, then shift up
                ctl.shift_en   = 1'b1;
                ctl.shift_byte = r_bits[63:56];
                n_bits = {r_bits[55:0], 8'h00};
                n_fill = r_fill + 6'd1;
                if (r_fill == 6'(BlockBytes - 1)) begin
                    ctl.start = 1'b1;
                    n_fin = 1'b1;
                    n_st  = S_WAIT;
                end
            end
            S_OUT: begin
                if (out_req) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == LastIdx) begin
                        ctl.restart = 1'b1;
                        n_fill = '0;
                        n_bits = '0;
                        n_pad  = 1'b0;
                        n_fin  = 1'b0;
                        n_end  = 1'b0;
                        n_st   = S_IDLE;
                    end
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_fill <= '0;
            r_bits <= '0;
            r_end  <= 1'b0;
            r_pad  <= 1'b0;
            r_fin  <= 1'b0;
            r_oidx <= '0;
        end else begin
            r_st   <= n_st;
            r_fill <= n_fill;
            r_bits <= n_bits;
            r_end  <= n_end;
            r_pad  <= n_pad;
            r_fin  <= n_fin;
            r_oidx <= n_oidx;
        end
    end

    assign i_in.ready        = (r_st == S_IDLE);
    assign o_out.valid       = (r_st == S_OUT);
    assign o_out.digest_word = word;
    assign o_out.word_index  = r_oidx;
    assign o_out.last_word   = (r_oidx == LastIdx);

`ifndef SYNTHESIS
    a_busy_only_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.busy |-> (r_st == S_WAIT))
        else $error("core busy outside the wait state");
    a_digest_from_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_WAIT && n_st == S_OUT) |-> (r_oidx == '0 && r_fill == '0))
        else $error("digest started off a block boundary");
    a_length_at_56: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_PADZ && n_st == S_PADL) |-> (r_fill == LenPosCnt))
        else $error("length field misplaced");
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_req && o_out.last_word) |=> (r_fill == '0 && r_bits == '0 && !r_pad))
        else $error("state not restored after digest");
`endif
endmodule
`default_nettype wire

### hw/rtl/shs_compress.sv
// SHA-256 compression core: 512-bit block buffer that doubles as the schedule
// window, one round per cycle, then a fold into the chaining words. Uses shs_pkg.
`default_nettype none
module shs_compress (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire shs_pkg::t_core_ctl  i_ctl,
    output      shs_pkg::t_core_stat o_stat,
    output      logic [31:0]       o_word
);
    import shs_pkg::*;

    typedef enum logic [2:0] {
        C_IDLE  = 3'b001,
        C_ROUND = 3'b010,
        C_FOLD  = 3'b100
    } t_cstate;

    t_cstate     r_st, n_st;
    logic [511:0] r_buf, n_buf;
    logic [31:0] r_h [DigestWords];
    logic [31:0] n_h [DigestWords];
    logic [31:0] r_v [DigestWords];
    logic [31:0] n_v [DigestWords];
    logic [5:0]  r_cnt, n_cnt;

    logic [31:0] w0, w1, w9, w14, w_new, sg0, sg1;
    logic [31:0] big0, big1, ch, maj, t1, t2;

    always_comb begin
        w0  = r_buf[511:480];
        w1  = r_buf[479:448];
        w9  = r_buf[223:192];
        w14 = r_buf[63:32];
        sg0 = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
        sg1 = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
        w_new = sg1 + w9 + sg0 + w0;
        big1 = {r_v[4][5:0], r_v[4][31:6]} ^ {r_v[4][10:0], r_v[4][31:11]}
             ^ {r_v[4][24:0], r_v[4][31:25]};
        ch   = r_v[6] ^ (r_v[4] & (r_v[5] ^ r_v[6]));
        t1   = r_v[7] + big1 + ch + RoundK[r_cnt] + w0;
        big0 = {r_v[0][1:0], r_v[0][31:2]} ^ {r_v[0][12:0], r_v[0][31:13]}
             ^ {r_v[0][21:0], r_v[0][31:22]};
        maj  = (r_v[0] & r_v[1]) | (r_v[2] & (r_v[0] | r_v[1]));
        t2   = big0 + maj;
    end

    always_comb begin
        n_st  = r_st;
        n_buf = r_buf;
        n_h   = r_h;
        n_v   = r_v;
        n_cnt = r_cnt;
        case (r_st)
            C_IDLE: begin
                if (i_ctl.shift_en) begin
                    n_buf = {r_buf[503:0], i_ctl.shift_byte};
                end
                if (i_ctl.restart) begin
                    n_h = HashInit;
                end
                if (i_ctl.start) begin
                    n_v   = r_h;
                    n_cnt = '0;
                    n_st  = C_ROUND;
                end
            end
            C_ROUND: begin
                n_buf = {r_buf[479:0], w_new};
                n_v[7] = r_v[6];
                n_v[6] = r_v[5];
                n_v[5] = r_v[4];
                n_v[4] = r_v[3] + t1;
                n_v[3] = r_v[2];
                n_v[2] = r_v[1];
                n_v[1] = r_v[0];
                n_v[0] = t1 + t2;
                n_cnt  = r_cnt + 6'd1;
                if (r_cnt == 6'(Rounds - 1)) begin
                    n_st = C_FOLD;
                end
            end
            C_FOLD: begin
                for (int i = 0; i < DigestWords; i++) begin
                    n_h[i] = r_h[i] + r_v[i];
                end
                n_st = C_IDLE;
            end
            default: n_st = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= C_IDLE;
            r_h  <= HashInit;
        end else begin
            r_st <= n_st;
            r_h  <= n_h;
        end
        r_buf <= n_buf;
        r_v   <= n_v;
        r_cnt <= n_cnt;
    end

    assign o_stat.busy = (r_st != C_IDLE);
    assign o_word      = r_h[i_ctl.rd_idx];

`ifndef SYNTHESIS
    a_fold_after_last_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == C_ROUND && r_cnt == 6'(Rounds - 1)) |=> (r_st == C_FOLD))
        else $error("fold did not follow the last round");
    a_round_count_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == C_IDLE && i_ctl.start) |=> (r_st == C_ROUND && r_cnt == '0))
        else $error("compression did not start at round zero");
    a_chain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == C_ROUND) |=> $stable(r_h[0]))
        else $error("chaining word moved during rounds");
`endif
endmodule
`default_nettype wire

### bench/sha256_digest_checker.sv
// Checker for the SHA-256 stream hasher: watches both channels, keeps its own
// hash state, predicts digest words and compares them. Uses shs_pkg, shs_if.
module sha256_digest_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    shs_in_if.sink    i_in_mon,
    shs_out_if.sink   i_out_mon,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_digests
);
    import shs_pkg::*;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_digest_beat;

    logic [31:0] chain_h [8];
    logic [7:0]  blk_bytes [64];
    logic [5:0]  fill_cnt;
    logic [63:0] msg_bits;
    t_digest_beat digest_q [$];

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_blk();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int t = 0; t < 16; t++)
            w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
        for (int t = 16; t < 64; t++)
            w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                 + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
        for (int t = 0; t < 8; t++) v[t] = chain_h[t];
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + (v[6] ^ (v[4] & (v[5] ^ v[6]))) + RoundK[t] + w[t];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) | (v[2] & (v[0] | v[1])));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int t = 0; t < 8; t++) chain_h[t] += v[t];
    endtask

    task automatic restart_msg();
        for (int t = 0; t < 8; t++) chain_h[t] = HashInit[t];
        fill_cnt = '0;
        msg_bits = '0;
    endtask

    task automatic absorb_request(logic [7:0] b, logic present, logic eom);
        int pos;
        if (present) begin
            blk_bytes[fill_cnt] = b;
            msg_bits += 64'd8;
            fill_cnt++;
            if (fill_cnt == 0) compress_blk();
        end
        if (!eom) return;
        pos = fill_cnt;
        blk_bytes[pos] = PadByte;
        pos++;
        if (pos > LenPos) begin
            while (pos < BlockBytes) blk_bytes[pos++] = 8'h00;
            compress_blk();
            pos = 0;
        end
        while (pos < LenPos) blk_bytes[pos++] = 8'h00;
        for (int k = 0; k < 8; k++) blk_bytes[LenPos + k] = msg_bits[63 - 8*k -: 8];
        compress_blk();
        for (int k = 0; k < 8; k++)
            digest_q.push_back(t_digest_beat'{chain_h[k], 3'(k), k == 7});
        restart_msg();
    endtask

    always @(posedge i_clk) begin
        t_digest_beat got, want;
        if (!i_rst_n) begin
            o_fail_count = 0;
            o_digests = 0;
            digest_q.delete();
            restart_msg();
        end else begin
            if (i_in_mon.valid && i_in_mon.ready)
                absorb_request(i_in_mon.data_byte, i_in_mon.byte_present,
                               i_in_mon.end_of_message);
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = '{i_out_mon.digest_word, i_out_mon.word_index, i_out_mon.last_word};
                if (digest_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected digest word %h idx %0d last %0d",
                                 got.digest_word, got.word_index, got.last_word);
                    o_fail_count++;
                end else begin
                    want = digest_q.pop_front();
                    if (got.last_word) o_digests++;
                    if (got !== want) begin
                        if (o_fail_count < 10)
                            $display("digest mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                                     want.digest_word, want.word_index, want.last_word,
                                     got.digest_word, got.word_index, got.last_word);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = digest_q.size();
    end
endmodule

### bench/tb_sha256_stream_hasher.sv
// Testbench top for the SHA-256 stream hasher: drives byte requests with random
// gaps and back-pressure, gives the verdict. Uses shs_if and sha256_digest_checker.
module tb_sha256_stream_hasher;
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count, pending, digests;
    int   cycle_cnt = 0;
    int   req_cnt = 0;
    logic stim_done = 1'b0;

    shs_in_if  in_ch ();
    shs_out_if out_ch ();

    sha256_stream_hasher i_dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch));

    sha256_digest_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_mon(in_ch), .i_out_mon(out_ch),
        .o_fail_count(fail_count), .o_pending(pending), .o_digests(digests)
    );

    initial forever #1 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data_byte = 8'h00;
        in_ch.byte_present = 1'b0;
        in_ch.end_of_message = 1'b0;
        out_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 400000) begin
            $display("[sha256_stream_hasher] ERROR");
            $finish;
        end
    end

    // sink: per-word random stall, with no-stall stretches
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            out_ch.ready = 1'b0;
            repeat (gap) @(negedge i_clk);
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // valid stays up after a handshake; the next request or a gap replaces it
    task automatic send_req(logic [7:0] b, logic present, logic eom, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 6);
        repeat (gap) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.byte_present <= present;
        in_ch.end_of_message <= eom;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        req_cnt++;
    endtask

    task automatic send_msg(int len, int fill_mode, bit end_with_byte);
        bit burst;
        logic [7:0] b;
        burst = $urandom_range(0, 3) == 0;
        for (int i = 0; i < len; i++) begin
            case (fill_mode)
                0: b = 8'h00;
                1: b = 8'hFF;
                default: b = 8'($urandom);
            endcase
            // occasional empty request inside the message
            if ($urandom_range(0, 15) == 0) send_req(8'($urandom), 1'b0, 1'b0, burst);
            send_req(b, 1'b1, end_with_byte && (i == len - 1), burst);
        end
        if (!end_with_byte || len == 0) send_req(8'($urandom), 1'b0, 1'b1, burst);
    endtask

    initial begin
        int len;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        // directed: empty, one byte with end, padding edges at 55/56
        send_msg(0, 2, 1'b0);
        send_req(8'h00, 1'b0, 1'b0, 1'b0);
        send_msg(1, 1, 1'b1);
        send_msg(3, 0, 1'b0);
        send_msg(55, 2, 1'b1);
        send_msg(56, 1, 1'b0);
        while (req_cnt < 170) begin
            case ($urandom_range(0, 5))
                0: len = $urandom_range(0, 8);
                1: len = $urandom_range(53, 66);
                2: len = $urandom_range(118, 130);
                default: len = $urandom_range(0, 40);
            endcase
            if (len > 190 - req_cnt) len = 190 - req_cnt;
            send_msg(len, $urandom_range(0, 5), $urandom_range(0, 1));
        end
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("sent %0d requests, checked %0d digests incl. empty and padding-edge messages",
                 req_cnt, digests);
        if (fail_count == 0 && pending == 0)
            $display("[sha256_stream_hasher] OK");
        else
            $display("[sha256_stream_hasher] ERROR");
        $finish;
    end
endmodule
